// ===== design/tarc_pkg.sv =====
// types and constants shared by the teach-and-replay axis controller
// no dependencies; used by tarc_ctrl, tarc_dp and the top level
package tarc_pkg;

    localparam int NUM_LIMITS    = 4;
    localparam int LIMIT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int COUNT_BITS    = 4;

    typedef enum logic [2:0]
    {
        OP_TICK,
        OP_JOG_UP,
        OP_JOG_DOWN,
        OP_SAVE,
        OP_CLEAR,
        OP_REPLAY,
        OP_REHOME
    } op_t;

    typedef enum logic [1:0]
    {
        MODE_HOMING,
        MODE_TEACH,
        MODE_REPLAY,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0]
    {
        MOTOR_NONE,
        MOTOR_FWD,
        MOTOR_BWD,
        MOTOR_OFF
    } motor_t;

    typedef enum logic [1:0]
    {
        SAVE_NONE,
        SAVE_STORED,
        SAVE_REJECTED
    } save_t;

    typedef enum logic [1:0]
    {
        POS_HOLD,
        POS_UP,
        POS_DOWN,
        POS_STEP_DOWN
    } pos_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SAVE,
        ST_FETCH,
        ST_STEP
    } ctrl_state_t;

    typedef struct packed
    {
        logic [2:0] op;
        logic [1:0] axis;
    } cmd_item_t;

    typedef struct packed
    {
        logic [1:0] motor_axis;
        logic [1:0] motor_cmd;
        logic [7:0] axis_position;
        logic [1:0] control_mode;
        logic [1:0] save_status;
        logic [3:0] stored_count;
    } res_item_t;

    typedef struct packed
    {
        pos_op_t                 pos_op;
        logic                    rd_en;
        logic                    rd_blank;
        logic                    wr_en;
        logic                    load_out;
        motor_t                  motor_cmd;
        mode_t                   mode;
        save_t                   save_status;
        logic [COUNT_BITS-1:0]   stored_count;
    } dp_cmd_t;

    typedef struct packed
    {
        logic sel_zero;
        logic row_match;
        logic diff_up;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/tarc_dp.sv =====
// datapath: axis position counters, limit registers, taught-position store,
// row compare and the result register; uses tarc_pkg, driven by tarc_ctrl
module tarc_dp #(
    parameter int STORE_ROWS = 8,
    parameter int AXIS_COUNT = 4,
    parameter int POS_BITS   = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [tarc_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [tarc_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    input  tarc_pkg::dp_cmd_t                          cmd,
    input  logic [$clog2(AXIS_COUNT)-1:0]              sel_axis,
    input  logic [(STORE_ROWS > 1 ? $clog2(STORE_ROWS) : 1)-1:0] row_addr,
    output tarc_pkg::dp_stat_t                         stat,
    output logic [$clog2(AXIS_COUNT)-1:0]              diff_axis,
    output logic                                       res_valid,
    input  logic                                       res_stall,
    output tarc_pkg::res_item_t                        res_item
);

    localparam int AXIS_BITS = $clog2(AXIS_COUNT);
    localparam int WIDE_BITS = (POS_BITS > tarc_pkg::LIMIT_BITS) ? POS_BITS
                                                                 : tarc_pkg::LIMIT_BITS;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef logic [AXIS_COUNT-1:0][POS_BITS-1:0] row_vec_t;

    logic [tarc_pkg::LIMIT_BITS-1:0] lim_max_reg [tarc_pkg::NUM_LIMITS];
    logic [tarc_pkg::LIMIT_BITS-1:0] lim_min_reg [tarc_pkg::NUM_LIMITS];

    row_vec_t pos_reg;
    row_vec_t mem [STORE_ROWS];
    row_vec_t rd_data_reg;
    logic     rd_blank_reg;
    row_vec_t row_data;

    logic                      res_valid_reg;
    logic                      res_valid_next;
    tarc_pkg::res_item_t       res_item_reg;

    logic [1:0]                lim_idx;
    logic [POS_BITS-1:0]       cur_pos;
    logic [POS_BITS-1:0]       new_pos;
    logic [POS_BITS-1:0]       pos_hi;
    logic [POS_BITS-1:0]       pos_lo;
    logic [WIDE_BITS-1:0]      max_wide;
    logic [WIDE_BITS-1:0]      min_wide;
    logic                      found;
    logic                      diff_up;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tarc_pkg::NUM_LIMITS; i++)
            begin
                lim_max_reg[i] <= tarc_pkg::LIMIT_BITS'(6);
                lim_min_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (int'(cfg_index) < tarc_pkg::NUM_LIMITS)
                lim_max_reg[cfg_index[1:0]] <= cfg_data;
            else
                lim_min_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // axes past the limit table share the last entry
    assign lim_idx  = (int'(sel_axis) > tarc_pkg::NUM_LIMITS - 1) ?
                      2'(tarc_pkg::NUM_LIMITS - 1) : 2'(sel_axis);
    assign max_wide = WIDE_BITS'(lim_max_reg[lim_idx]);
    assign min_wide = WIDE_BITS'(lim_min_reg[lim_idx]);
    assign pos_hi   = (max_wide > WIDE_BITS'(POS_MAX)) ? POS_MAX : POS_BITS'(max_wide);
    assign pos_lo   = (min_wide > WIDE_BITS'(POS_MAX)) ? POS_MAX : POS_BITS'(min_wide);

    assign cur_pos  = pos_reg[sel_axis];

    always_comb
    begin
        case (cmd.pos_op)
            tarc_pkg::POS_UP:        new_pos = (cur_pos >= pos_hi) ? pos_hi : cur_pos + 1'b1;
            tarc_pkg::POS_DOWN:      new_pos = (cur_pos <= pos_lo) ? pos_lo : cur_pos - 1'b1;
            tarc_pkg::POS_STEP_DOWN: new_pos = cur_pos - 1'b1;
            default:                 new_pos = cur_pos;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (cmd.pos_op != tarc_pkg::POS_HOLD)
            pos_reg[sel_axis] <= new_pos;
    end

    // store of taught rows, one row per address
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[row_addr] <= pos_reg;
        if (cmd.rd_en)
        begin
            rd_data_reg  <= mem[row_addr];
            rd_blank_reg <= cmd.rd_blank;
        end
    end

    // rows past the fill count read as cleared
    assign row_data = rd_blank_reg ? '0 : rd_data_reg;

    // lowest axis that differs from the fetched row
    always_comb
    begin
        found     = 1'b0;
        diff_axis = '0;
        diff_up   = 1'b0;
        for (int a = AXIS_COUNT - 1; a >= 0; a--)
        begin
            if (pos_reg[a] != row_data[a])
            begin
                found     = 1'b1;
                diff_axis = AXIS_BITS'(a);
                diff_up   = pos_reg[a] < row_data[a];
            end
        end
    end

    assign stat.diff_up   = diff_up;
    assign stat.row_match = !found;
    assign stat.sel_zero  = (cur_pos == '0);
    assign stat.out_free  = !res_valid_reg || !res_stall;

    // result register
    always_comb
    begin
        if (cmd.load_out)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_item_reg.motor_axis    <= 2'(sel_axis);
            res_item_reg.motor_cmd     <= cmd.motor_cmd;
            res_item_reg.axis_position <= 8'(new_pos);
            res_item_reg.control_mode  <= cmd.mode;
            res_item_reg.save_status   <= cmd.save_status;
            res_item_reg.stored_count  <= cmd.stored_count;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// ===== design/tarc_ctrl.sv =====
// controller: mode, homing and replay sequencing, store fill count and
// the save scan; uses tarc_pkg, drives tarc_dp through command and status
module tarc_ctrl #(
    parameter int STORE_ROWS = 8,
    parameter int AXIS_COUNT = 4
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cmd_valid,
    output logic                                       cmd_stall,
    input  tarc_pkg::cmd_item_t                        cmd_item,
    output tarc_pkg::dp_cmd_t                          cmd,
    output logic [$clog2(AXIS_COUNT)-1:0]              sel_axis,
    output logic [(STORE_ROWS > 1 ? $clog2(STORE_ROWS) : 1)-1:0] row_addr,
    input  tarc_pkg::dp_stat_t                         stat,
    input  logic [$clog2(AXIS_COUNT)-1:0]              diff_axis
);

    localparam int AXIS_BITS = $clog2(AXIS_COUNT);
    localparam int ROW_BITS  = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int CNT_BITS  = $clog2(STORE_ROWS + 1);
    localparam int HOME_BITS = $clog2(AXIS_COUNT + 1);

    tarc_pkg::ctrl_state_t state_reg, state_next;
    tarc_pkg::mode_t       mode_reg, mode_next;

    logic [2:0]            op_reg;
    logic [1:0]            axis_reg;
    logic [CNT_BITS-1:0]   used_reg, used_next;
    logic [CNT_BITS-1:0]   replay_row_reg, replay_row_next;
    logic [CNT_BITS-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                  dup_reg, dup_next;
    logic [HOME_BITS-1:0]  home_axis_reg, home_axis_next;
    logic                  after_replay_reg, after_replay_next;
    logic [HOME_BITS-1:0]  home_last;
    logic                  accept;
    logic                  jog_ok;

    assign accept    = cmd_valid && (state_reg == tarc_pkg::ST_IDLE);
    assign cmd_stall = (state_reg != tarc_pkg::ST_IDLE);
    assign home_last = after_replay_reg ? HOME_BITS'(AXIS_COUNT - 1) : HOME_BITS'(AXIS_COUNT);
    assign jog_ok    = (op_reg == tarc_pkg::OP_JOG_UP || op_reg == tarc_pkg::OP_JOG_DOWN)
                       && (int'(axis_reg) < AXIS_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tarc_pkg::ST_IDLE;
            mode_reg         <= tarc_pkg::MODE_HOMING;
            used_reg         <= '0;
            replay_row_reg   <= '0;
            scan_cnt_reg     <= '0;
            dup_reg          <= 1'b0;
            home_axis_reg    <= '0;
            after_replay_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            used_reg         <= used_next;
            replay_row_reg   <= replay_row_next;
            scan_cnt_reg     <= scan_cnt_next;
            dup_reg          <= dup_next;
            home_axis_reg    <= home_axis_next;
            after_replay_reg <= after_replay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd_item.op;
            axis_reg <= cmd_item.axis;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tarc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_item.op == tarc_pkg::OP_SAVE && mode_reg == tarc_pkg::MODE_TEACH)
                        state_next = tarc_pkg::ST_SCAN;
                    else if (cmd_item.op == tarc_pkg::OP_TICK
                             && mode_reg == tarc_pkg::MODE_REPLAY
                             && replay_row_reg < used_reg)
                        state_next = tarc_pkg::ST_FETCH;
                    else
                        state_next = tarc_pkg::ST_EXEC;
                end
            end
            tarc_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_BITS'(STORE_ROWS))
                    state_next = tarc_pkg::ST_SAVE;
            end
            tarc_pkg::ST_FETCH:
                state_next = tarc_pkg::ST_STEP;
            tarc_pkg::ST_EXEC, tarc_pkg::ST_SAVE, tarc_pkg::ST_STEP:
            begin
                if (stat.out_free)
                    state_next = tarc_pkg::ST_IDLE;
            end
            default:
                state_next = tarc_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath and bookkeeping updates
    always_comb
    begin
        cmd.pos_op        = tarc_pkg::POS_HOLD;
        cmd.rd_en         = 1'b0;
        cmd.rd_blank      = 1'b0;
        cmd.wr_en         = 1'b0;
        cmd.load_out      = 1'b0;
        cmd.motor_cmd     = tarc_pkg::MOTOR_NONE;
        cmd.save_status   = tarc_pkg::SAVE_NONE;
        sel_axis          = '0;
        row_addr          = '0;
        mode_next         = mode_reg;
        used_next         = used_reg;
        replay_row_next   = replay_row_reg;
        scan_cnt_next     = scan_cnt_reg;
        dup_next          = dup_reg;
        home_axis_next    = home_axis_reg;
        after_replay_next = after_replay_reg;

        case (state_reg)
            tarc_pkg::ST_IDLE:
            begin
                scan_cnt_next = '0;
                dup_next      = 1'b0;
            end
            tarc_pkg::ST_SCAN:
            begin
                // read one row per cycle, compare the row fetched the cycle before
                if (scan_cnt_reg != CNT_BITS'(STORE_ROWS))
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_blank  = (scan_cnt_reg >= used_reg);
                    row_addr      = scan_cnt_reg[ROW_BITS-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (scan_cnt_reg != '0)
                    dup_next = dup_reg || stat.row_match;
            end
            tarc_pkg::ST_SAVE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (!dup_reg && used_reg < CNT_BITS'(STORE_ROWS))
                    begin
                        cmd.wr_en       = 1'b1;
                        row_addr        = used_reg[ROW_BITS-1:0];
                        used_next       = used_reg + 1'b1;
                        cmd.save_status = tarc_pkg::SAVE_STORED;
                    end
                    else
                    begin
                        cmd.save_status = tarc_pkg::SAVE_REJECTED;
                    end
                    mode_next         = tarc_pkg::MODE_HOMING;
                    home_axis_next    = '0;
                    after_replay_next = 1'b0;
                end
            end
            tarc_pkg::ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
                row_addr  = replay_row_reg[ROW_BITS-1:0];
            end
            tarc_pkg::ST_STEP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (!stat.row_match)
                    begin
                        sel_axis      = diff_axis;
                        cmd.pos_op    = stat.diff_up ? tarc_pkg::POS_UP : tarc_pkg::POS_DOWN;
                        cmd.motor_cmd = stat.diff_up ? tarc_pkg::MOTOR_FWD : tarc_pkg::MOTOR_BWD;
                    end
                    else
                    begin
                        replay_row_next   = replay_row_reg + 1'b1;
                        mode_next         = tarc_pkg::MODE_HOMING;
                        home_axis_next    = '0;
                        after_replay_next = 1'b1;
                    end
                end
            end
            tarc_pkg::ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (op_reg == tarc_pkg::OP_REHOME)
                    begin
                        mode_next         = tarc_pkg::MODE_HOMING;
                        home_axis_next    = '0;
                        after_replay_next = 1'b0;
                    end
                    else
                    begin
                        case (mode_reg)
                            tarc_pkg::MODE_HOMING:
                            begin
                                if (op_reg == tarc_pkg::OP_TICK)
                                begin
                                    if (home_axis_reg < home_last)
                                    begin
                                        sel_axis = AXIS_BITS'(home_axis_reg);
                                        if (stat.sel_zero)
                                        begin
                                            cmd.motor_cmd  = tarc_pkg::MOTOR_OFF;
                                            home_axis_next = home_axis_reg + 1'b1;
                                        end
                                        else
                                        begin
                                            cmd.pos_op    = tarc_pkg::POS_STEP_DOWN;
                                            cmd.motor_cmd = tarc_pkg::MOTOR_BWD;
                                        end
                                    end
                                    else
                                    begin
                                        home_axis_next = '0;
                                        if (after_replay_reg)
                                        begin
                                            // last axis is left at its position, only switched off
                                            after_replay_next = 1'b0;
                                            sel_axis          = AXIS_BITS'(AXIS_COUNT - 1);
                                            cmd.motor_cmd     = tarc_pkg::MOTOR_OFF;
                                            mode_next         = tarc_pkg::MODE_REPLAY;
                                        end
                                        else
                                        begin
                                            mode_next = tarc_pkg::MODE_TEACH;
                                        end
                                    end
                                end
                            end
                            tarc_pkg::MODE_TEACH:
                            begin
                                if (jog_ok)
                                begin
                                    sel_axis = AXIS_BITS'(axis_reg);
                                    if (op_reg == tarc_pkg::OP_JOG_UP)
                                    begin
                                        cmd.pos_op    = tarc_pkg::POS_UP;
                                        cmd.motor_cmd = tarc_pkg::MOTOR_FWD;
                                    end
                                    else
                                    begin
                                        cmd.pos_op    = tarc_pkg::POS_DOWN;
                                        cmd.motor_cmd = tarc_pkg::MOTOR_BWD;
                                    end
                                end
                                else if (op_reg == tarc_pkg::OP_CLEAR)
                                begin
                                    used_next = '0;
                                end
                                else if (op_reg == tarc_pkg::OP_REPLAY)
                                begin
                                    mode_next       = tarc_pkg::MODE_REPLAY;
                                    replay_row_next = '0;
                                end
                            end
                            tarc_pkg::MODE_REPLAY:
                            begin
                                // rows are handled in the fetch path; here none is left
                                if (op_reg == tarc_pkg::OP_TICK)
                                    mode_next = tarc_pkg::MODE_DONE;
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        cmd.mode         = mode_next;
        cmd.stored_count = tarc_pkg::COUNT_BITS'(used_next);
    end

endmodule

// ===== design/teach_and_replay_axis_controller_top.sv =====
// Teach-and-replay sequencer for up to four axes. One command is taken per
// transfer and gives exactly one result transfer. Jogs, clear, replay start,
// rehome, homing ticks and the replay tick that finds no row left go from
// accept through the execute state to the result register; a replay tick
// that steps toward a stored row first reads the row store; a save first
// runs the duplicate check that reads and compares one store row per cycle
// over the whole store. The next command is taken as soon as the result
// sits in the output register, even while that result is stalled. The user
// must write limits on the cfg port only while no command is in flight; the
// block does not enforce it. Depends on tarc_pkg, tarc_ctrl and tarc_dp.
module teach_and_replay_axis_controller_top #(
    parameter int STORE_ROWS = 8,
    parameter int AXIS_COUNT = 4,
    parameter int POS_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tarc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tarc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  tarc_pkg::cmd_item_t                 cmd_item,
    output logic                                res_valid,
    input  logic                                res_stall,
    output tarc_pkg::res_item_t                 res_item
);

    localparam int AXIS_BITS = $clog2(AXIS_COUNT);
    localparam int ROW_BITS  = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

    tarc_pkg::dp_cmd_t       dp_cmd;
    tarc_pkg::dp_stat_t      dp_stat;
    logic [AXIS_BITS-1:0]    sel_axis;
    logic [AXIS_BITS-1:0]    diff_axis;
    logic [ROW_BITS-1:0]     row_addr;

    tarc_ctrl #(
        .STORE_ROWS (STORE_ROWS),
        .AXIS_COUNT (AXIS_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .cmd       (dp_cmd),
        .sel_axis  (sel_axis),
        .row_addr  (row_addr),
        .stat      (dp_stat),
        .diff_axis (diff_axis)
    );

    tarc_dp #(
        .STORE_ROWS (STORE_ROWS),
        .AXIS_COUNT (AXIS_COUNT),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .sel_axis  (sel_axis),
        .row_addr  (row_addr),
        .stat      (dp_stat),
        .diff_axis (diff_axis),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
